### src/hllc_star_state_solver_macros.svh
// assertion macros for the hllc star state solver checker
`ifndef HLLC_STAR_STATE_SOLVER_MACROS_SVH
`define HLLC_STAR_STATE_SOLVER_MACROS_SVH

// property that holds at every edge outside reset
`define HLLC_CHECK(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("hllc check failed");

// property whose consequent must hold in the cycle after its antecedent
`define HLLC_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hllc check failed");

`endif

### src/hllc_pkg.sv
// shared widths, limits and stage records for the hllc star state solver
package hllc_pkg;

  localparam int VW  = 32;        // signed velocity and result width
  localparam int UW  = 31;        // unsigned state field width
  localparam int DSW = 35;        // wave speed minus velocity
  localparam int MW  = 66;        // density times wave speed offset
  localparam int DW  = 67;        // denominator
  localparam int DMW = DW - 1;    // denominator magnitude
  localparam int NW  = 100;       // numerator
  localparam int NMW = NW - 1;    // numerator magnitude
  localparam int PW  = 100;       // star pressure before scaling
  localparam int QW  = 32;        // quotient bits, one per divider stage
  localparam int FB  = 16 * 2;    // fraction bits of a Q32.32 product of two Q16.16 values

  localparam logic signed [VW-1:0] SMAX = 32'sh7fffffff;
  localparam logic signed [VW-1:0] SMIN = 32'sh80000000;
  localparam logic [QW-1:0]        NEG_LIMIT = 32'h80000000;

  typedef struct packed {
    logic signed [MW-1:0] ml;
    logic signed [VW-1:0] vl;
    logic [UW-1:0]        pl;
    logic                 zero;
    logic                 neg;
    logic                 ovf;
  } side_t;

  typedef struct packed {
    logic [DMW-1:0] rem;
    logic [QW-1:0]  nlo;
    logic [QW-1:0]  q;
    logic [DMW-1:0] dmag;
  } div_t;

endpackage

### src/hllc_star_state_solver.sv
// hllc star state solver top level
// six front stages, 33 divider stages and six back stages lie between an accepted word and its result word
// throughput: one word per cycle while the result word is not stalled, every stage is a register
// a stalled result word halts every stage, nothing is dropped or repeated
// rst is synchronous and clears all valid bits, data registers keep their value
module hllc_star_state_solver (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  logic [hllc_pkg::UW-1:0]     left_density,
  input  logic [hllc_pkg::UW-1:0]     left_pressure,
  input  logic signed [hllc_pkg::VW-1:0] left_velocity,
  input  logic [hllc_pkg::UW-1:0]     left_sound_speed,
  input  logic [hllc_pkg::UW-1:0]     right_density,
  input  logic [hllc_pkg::UW-1:0]     right_pressure,
  input  logic signed [hllc_pkg::VW-1:0] right_velocity,
  input  logic [hllc_pkg::UW-1:0]     right_sound_speed,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic signed [hllc_pkg::VW-1:0] star_velocity,
  output logic signed [hllc_pkg::VW-1:0] star_pressure,
  output logic                        divide_fault,
  output logic                        saturated
);
  import hllc_pkg::*;

  logic en;

  // wave speed bounds
  logic signed [VW:0]    sl_l, sl_r, sr_l, sr_r, sl_c, sr_c;
  logic signed [DSW-1:0] dsl_c, dsr_c;

  logic                  v1, v2, v3, v4, v5, v6;
  logic [UW-1:0]         s1_dl, s1_dr, s1_pl, s1_pr;
  logic signed [VW-1:0]  s1_vl, s1_vr;
  logic signed [DSW-1:0] s1_dsl, s1_dsr;

  logic signed [MW-1:0]  s2_ml, s2_mr;
  logic [UW-1:0]         s2_pl, s2_pr;
  logic signed [VW-1:0]  s2_vl, s2_vr;

  logic signed [DW-1:0]  s3_den;
  logic signed [MW-1:0]  s3_plh, s3_prh;
  logic signed [VW+32:0] s3_pll, s3_prl;
  logic signed [VW:0]    s3_dp;
  logic signed [MW-1:0]  s3_ml;
  logic signed [VW-1:0]  s3_vl;
  logic [UW-1:0]         s3_pl;

  logic signed [NW-1:0]  s4_mvl, s4_mvr;
  logic signed [DW-1:0]  s4_den;
  logic signed [VW:0]    s4_dp;
  logic signed [MW-1:0]  s4_ml;
  logic signed [VW-1:0]  s4_vl;
  logic [UW-1:0]         s4_pl;

  logic signed [NW-1:0]  s5_num;
  logic signed [DW-1:0]  s5_den;
  logic                  s5_zero;
  logic signed [MW-1:0]  s5_ml;
  logic signed [VW-1:0]  s5_vl;
  logic [UW-1:0]         s5_pl;

  logic [NMW-1:0]        s6_nmag;
  logic [DMW-1:0]        s6_dmag;
  logic                  s6_neg, s6_zero;
  logic signed [MW-1:0]  s6_ml;
  logic signed [VW-1:0]  s6_vl;
  logic [UW-1:0]         s6_pl;

  div_t                  dv  [0:QW];
  side_t                 sdv [0:QW];
  logic                  vd  [0:QW];

  // velocity sign and clip
  logic                  va, vb, vc, ve, vf;
  logic signed [VW-1:0]  sa_u, sa_u_next;
  logic                  sa_clip, sa_clip_next, sa_zero;
  logic signed [MW-1:0]  sa_ml;
  logic signed [VW-1:0]  sa_vl;
  logic [UW-1:0]         sa_pl;

  logic signed [VW:0]    sb_du;
  logic signed [VW-1:0]  sb_u;
  logic                  sb_clip, sb_zero;
  logic signed [MW-1:0]  sb_ml;
  logic [UW-1:0]         sb_pl;

  logic signed [MW:0]    sc_ph;
  logic signed [VW+33:0] sc_plo;
  logic signed [VW-1:0]  sc_u;
  logic                  sc_clip, sc_zero;
  logic [UW-1:0]         sc_pl;

  logic signed [PW-1:0]  se_p, se_p_next;
  logic signed [VW-1:0]  se_u;
  logic                  se_clip, se_zero;

  logic signed [PW-FB-1:0] sf_pr, sf_pr_next;
  logic signed [VW-1:0]    sf_u;
  logic                    sf_clip, sf_zero;

  logic signed [VW-1:0]  ps_c;
  logic                  pclip_c;

  assign en         = !result_valid || !result_stall;
  assign item_stall = !en;

  always_comb begin
    sl_l  = (VW+1)'(left_velocity) - (VW+1)'(left_sound_speed);
    sl_r  = (VW+1)'(right_velocity) - (VW+1)'(right_sound_speed);
    sr_l  = (VW+1)'(left_velocity) + (VW+1)'(left_sound_speed);
    sr_r  = (VW+1)'(right_velocity) + (VW+1)'(right_sound_speed);
    sl_c  = (sl_l < sl_r) ? sl_l : sl_r;
    sr_c  = (sr_l > sr_r) ? sr_l : sr_r;
    dsl_c = DSW'(sl_c) - DSW'(left_velocity);
    dsr_c = DSW'(sr_c) - DSW'(right_velocity);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      vd[0] <= 1'b0;
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; ve <= 1'b0; vf <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1 <= item_valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      vd[0] <= v6;
      va <= vd[QW]; vb <= va; vc <= vb; ve <= vc; vf <= ve;
      result_valid <= vf;
    end
  end

  // front stages: products, numerator, magnitudes
  always_ff @(posedge clk) begin
    if (en) begin
      s1_dl  <= left_density;
      s1_dr  <= right_density;
      s1_pl  <= left_pressure;
      s1_pr  <= right_pressure;
      s1_vl  <= left_velocity;
      s1_vr  <= right_velocity;
      s1_dsl <= dsl_c;
      s1_dsr <= dsr_c;

      s2_ml <= MW'($signed({1'b0, s1_dl}) * s1_dsl);
      s2_mr <= MW'($signed({1'b0, s1_dr}) * s1_dsr);
      s2_pl <= s1_pl;
      s2_pr <= s1_pr;
      s2_vl <= s1_vl;
      s2_vr <= s1_vr;

      s3_den <= DW'(s2_ml) - DW'(s2_mr);
      s3_plh <= MW'($signed(s2_ml[MW-1:FB]) * s2_vl);
      s3_prh <= MW'($signed(s2_mr[MW-1:FB]) * s2_vr);
      s3_pll <= (VW+33)'($signed({1'b0, s2_ml[FB-1:0]}) * s2_vl);
      s3_prl <= (VW+33)'($signed({1'b0, s2_mr[FB-1:0]}) * s2_vr);
      s3_dp  <= (VW+1)'({2'b00, s2_pr}) - (VW+1)'({2'b00, s2_pl});
      s3_ml  <= s2_ml;
      s3_vl  <= s2_vl;
      s3_pl  <= s2_pl;

      s4_mvl <= (NW'(s3_plh) <<< FB) + NW'(s3_pll);
      s4_mvr <= (NW'(s3_prh) <<< FB) + NW'(s3_prl);
      s4_den <= s3_den;
      s4_dp  <= s3_dp;
      s4_ml  <= s3_ml;
      s4_vl  <= s3_vl;
      s4_pl  <= s3_pl;

      s5_num  <= (NW'(s4_dp) <<< FB) + s4_mvl - s4_mvr;
      s5_den  <= s4_den;
      s5_zero <= (s4_den == '0);
      s5_ml   <= s4_ml;
      s5_vl   <= s4_vl;
      s5_pl   <= s4_pl;

      s6_nmag <= NMW'(s5_num[NW-1] ? -s5_num : s5_num);
      s6_dmag <= DMW'(s5_den[DW-1] ? -s5_den : s5_den);
      s6_neg  <= s5_num[NW-1] ^ s5_den[DW-1];
      s6_zero <= s5_zero;
      s6_ml   <= s5_ml;
      s6_vl   <= s5_vl;
      s6_pl   <= s5_pl;

      dv[0].rem   <= s6_nmag[DMW+FB-1:FB];
      dv[0].nlo   <= s6_nmag[QW-1:0];
      dv[0].q     <= '0;
      dv[0].dmag  <= s6_dmag;
      sdv[0].ml   <= s6_ml;
      sdv[0].vl   <= s6_vl;
      sdv[0].pl   <= s6_pl;
      sdv[0].zero <= s6_zero;
      sdv[0].neg  <= s6_neg;
      sdv[0].ovf  <= (s6_nmag[NMW-1:FB] >= {1'b0, s6_dmag});
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DMW:0] t;
    logic         ge;

    assign t  = {dv[k].rem, dv[k].nlo[QW-1]};
    assign ge = (t >= {1'b0, dv[k].dmag});

    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k+1] <= 1'b0;
      end else if (en) begin
        vd[k+1] <= vd[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1].rem  <= ge ? DMW'(t - {1'b0, dv[k].dmag}) : DMW'(t);
        dv[k+1].nlo  <= {dv[k].nlo[QW-2:0], 1'b0};
        dv[k+1].q    <= {dv[k].q[QW-2:0], ge};
        dv[k+1].dmag <= dv[k].dmag;
        sdv[k+1]     <= sdv[k];
      end
    end
  end

  always_comb begin
    if (sdv[QW].neg) begin
      sa_clip_next = sdv[QW].ovf || (dv[QW].q > NEG_LIMIT);
      sa_u_next    = sa_clip_next ? SMIN : $signed(-dv[QW].q);
    end else begin
      sa_clip_next = sdv[QW].ovf || dv[QW].q[QW-1];
      sa_u_next    = sa_clip_next ? SMAX : $signed(dv[QW].q);
    end
  end

  always_comb begin
    se_p_next = (PW'({1'b0, sc_pl}) <<< FB) + (PW'(sc_ph) <<< FB) + PW'(sc_plo);
    sf_pr_next = (PW-FB)'((se_p + (se_p[PW-1] ? PW'(33'h0ffffffff) : PW'(0))) >>> FB);
  end

  always_comb begin
    pclip_c = 1'b0;
    ps_c    = sf_pr[VW-1:0];
    if (sf_pr > (PW-FB)'(SMAX)) begin
      pclip_c = 1'b1;
      ps_c    = SMAX;
    end else if (sf_pr < (PW-FB)'(SMIN)) begin
      pclip_c = 1'b1;
      ps_c    = SMIN;
    end
  end

  // back stages: velocity sign and clip, star pressure and result word
  always_ff @(posedge clk) begin
    if (en) begin
      sa_u    <= sa_u_next;
      sa_clip <= sa_clip_next;
      sa_zero <= sdv[QW].zero;
      sa_ml   <= sdv[QW].ml;
      sa_vl   <= sdv[QW].vl;
      sa_pl   <= sdv[QW].pl;

      sb_du   <= (VW+1)'(sa_u) - (VW+1)'(sa_vl);
      sb_u    <= sa_u;
      sb_clip <= sa_clip;
      sb_zero <= sa_zero;
      sb_ml   <= sa_ml;
      sb_pl   <= sa_pl;

      sc_ph   <= (MW+1)'($signed(sb_ml[MW-1:FB]) * sb_du);
      sc_plo  <= (VW+34)'($signed({1'b0, sb_ml[FB-1:0]}) * sb_du);
      sc_u    <= sb_u;
      sc_clip <= sb_clip;
      sc_zero <= sb_zero;
      sc_pl   <= sb_pl;

      se_p    <= se_p_next;
      se_u    <= sc_u;
      se_clip <= sc_clip;
      se_zero <= sc_zero;

      sf_pr   <= sf_pr_next;
      sf_u    <= se_u;
      sf_clip <= se_clip;
      sf_zero <= se_zero;

      star_velocity <= sf_zero ? '0 : sf_u;
      star_pressure <= sf_zero ? '0 : ps_c;
      divide_fault  <= sf_zero;
      saturated     <= !sf_zero && (sf_clip || pclip_c);
    end
  end

endmodule

### src/hllc_chk.sv
// port checker for the hllc star state solver and its bind
`include "hllc_star_state_solver_macros.svh"

module hllc_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_stall,
  input logic                           result_valid,
  input logic                           result_stall,
  input logic signed [hllc_pkg::VW-1:0] star_velocity,
  input logic signed [hllc_pkg::VW-1:0] star_pressure,
  input logic                           divide_fault,
  input logic                           saturated
);

  // a faulted word carries zero results and no clip
  `HLLC_CHECK(a_fault_zero, result_valid && divide_fault |-> star_velocity == 0 && star_pressure == 0 && !saturated)

  // an empty output register never holds back the input side
  `HLLC_CHECK(a_drain_free, !result_valid |-> !item_stall)

  // a stalled result word stays put
  `HLLC_CHECK_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(star_velocity) && $stable(star_pressure))

endmodule

bind hllc_star_state_solver hllc_chk u_chk (.*);

### sim/testbench.sv
// self-checking testbench for the hllc star state solver, random and directed interface words
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import hllc_pkg::*;

  typedef struct {
    logic [UW-1:0]        dl, pl, cl, dr, pr, cr;
    logic signed [VW-1:0] vl, vr;
  } iface_t;

  typedef struct {
    logic signed [VW-1:0] u, p;
    logic                 fault, sat;
  } star_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 120;

  class star_scoreboard;
    star_t pending_star[$];
    int    errors;

    function automatic logic signed [VW-1:0] clip32(logic signed [127:0] x, ref logic sat);
      if (x > 128'sd2147483647) begin
        sat = 1'b1;
        return SMAX;
      end
      if (x < -128'sd2147483648) begin
        sat = 1'b1;
        return SMIN;
      end
      return x[VW-1:0];
    endfunction

    function automatic star_t solve_star_state(iface_t w);
      logic signed [127:0] dl, pl, vl, cl, dr, pr, vr, cr, sl, sr, ml, mr, den, num, q, pw;
      star_t r;
      dl = w.dl; pl = w.pl; cl = w.cl; vl = w.vl;
      dr = w.dr; pr = w.pr; cr = w.cr; vr = w.vr;
      sl = (vl - cl < vr - cr) ? vl - cl : vr - cr;
      sr = (vl + cl > vr + cr) ? vl + cl : vr + cr;
      ml = dl * (sl - vl);
      mr = dr * (sr - vr);
      den = ml - mr;
      r.fault = 1'b0;
      r.sat = 1'b0;
      if (den == 0) begin
        r.u = '0;
        r.p = '0;
        r.fault = 1'b1;
        return r;
      end
      num = (pr - pl) * 128'sd4294967296 + ml * vl - mr * vr;
      q = num / den;
      r.u = clip32(q, r.sat);
      pw = pl * 128'sd4294967296 + ml * (128'(signed'(r.u)) - vl);
      pw = pw / 128'sd4294967296;
      r.p = clip32(pw, r.sat);
      return r;
    endfunction

    function void note_word(iface_t w);
      pending_star.push_back(solve_star_state(w));
    endfunction

    function void check_word(star_t got);
      star_t want;
      if (pending_star.size() == 0) begin
        $error("result word with no expectation");
        errors++;
        return;
      end
      want = pending_star.pop_front();
      if (got.u !== want.u) begin
        $error("star_velocity expected %h actual %h", want.u, got.u);
        errors++;
      end
      if (got.p !== want.p) begin
        $error("star_pressure expected %h actual %h", want.p, got.p);
        errors++;
      end
      if (got.fault !== want.fault) begin
        $error("divide_fault expected %b actual %b", want.fault, got.fault);
        errors++;
      end
      if (got.sat !== want.sat) begin
        $error("saturated expected %b actual %b", want.sat, got.sat);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic item_valid, item_stall, result_valid, result_stall;
  logic [UW-1:0] left_density, left_pressure, left_sound_speed;
  logic [UW-1:0] right_density, right_pressure, right_sound_speed;
  logic signed [VW-1:0] left_velocity, right_velocity, star_velocity, star_pressure;
  logic divide_fault, saturated;

  star_scoreboard sb = new();
  int phase;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;
  bit timed_out;

  hllc_star_state_solver u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always_comb begin
    case (phase)
      0: begin send_idle_pct = 28; recv_idle_pct = 61; end
      1: begin send_idle_pct = 61; recv_idle_pct = 28; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  end

  // receiver side
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall)
        sb.check_word('{u: star_velocity, p: star_pressure, fault: divide_fault,
                        sat: saturated});
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out <= 1'b1;
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_word(iface_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid        <= 1'b1;
    left_density      <= w.dl;
    left_pressure     <= w.pl;
    left_velocity     <= w.vl;
    left_sound_speed  <= w.cl;
    right_density     <= w.dr;
    right_pressure    <= w.pr;
    right_velocity    <= w.vr;
    right_sound_speed <= w.cr;
    do @(posedge clk); while (item_stall);
    sb.note_word(w);
  endtask

  function automatic iface_t make_word(logic [UW-1:0] dl, pl, logic signed [VW-1:0] vl,
                                       logic [UW-1:0] cl, dr, pr, logic signed [VW-1:0] vr,
                                       logic [UW-1:0] cr);
    iface_t w;
    w.dl = dl; w.pl = pl; w.vl = vl; w.cl = cl;
    w.dr = dr; w.pr = pr; w.vr = vr; w.cr = cr;
    return w;
  endfunction

  // physical-looking state around 1.0 in q16.16
  function automatic iface_t make_plausible();
    iface_t w;
    w.dl = UW'($urandom_range(32'h0004_0000, 1));
    w.pl = UW'($urandom_range(32'h0004_0000, 0));
    w.cl = UW'($urandom_range(32'h0003_0000, 0));
    w.dr = UW'($urandom_range(32'h0004_0000, 1));
    w.pr = UW'($urandom_range(32'h0004_0000, 0));
    w.cr = UW'($urandom_range(32'h0003_0000, 0));
    w.vl = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    w.vr = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    return w;
  endfunction

  function automatic iface_t make_raw();
    iface_t w;
    w.dl = UW'($urandom); w.pl = UW'($urandom); w.vl = $urandom; w.cl = UW'($urandom);
    w.dr = UW'($urandom); w.pr = UW'($urandom); w.vr = $urandom; w.cr = UW'($urandom);
    if ($urandom_range(3) == 0) w.dl = '0;
    if ($urandom_range(3) == 0) w.dr = '0;
    if ($urandom_range(3) == 0) w.cl = UW'($urandom_range(255));
    if ($urandom_range(3) == 0) w.cr = UW'($urandom_range(255));
    return w;
  endfunction

  initial begin
    iface_t w;
    phase = 0;
    timed_out = 1'b0;
    quiet_cycles = 0;
    rst = 1'b1;
    item_valid <= 1'b0;
    result_stall <= 1'b0;
    left_density <= '0; left_pressure <= '0; left_velocity <= '0; left_sound_speed <= '0;
    right_density <= '0; right_pressure <= '0; right_velocity <= '0; right_sound_speed <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // all zero, zero densities, zero wave offsets: divide fault
    send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(0, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff,
                        0, 31'h7fffffff, SMIN, 31'h7fffffff));
    send_word(make_word(31'h10000, 31'h10000, 32'sh10000, 0,
                        31'h10000, 31'h20000, 32'sh10000, 0));
    // extremes of every field
    send_word(make_word(31'h7fffffff, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff,
                        31'h7fffffff, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff));
    send_word(make_word(31'h7fffffff, 0, SMIN, 31'h7fffffff,
                        31'h7fffffff, 31'h7fffffff, 32'sh7fffffff, 31'h7fffffff));
    send_word(make_word(31'h7fffffff, 31'h7fffffff, 32'sh7fffffff, 0,
                        1, 0, SMIN, 0));
    send_word(make_word(1, 31'h7fffffff, SMIN, 1, 1, 0, 32'sh7fffffff, 1));
    send_word(make_word(1, 0, 32'sh7fffffff, 1, 1, 31'h7fffffff, SMIN, 1));
    // sod-like shock tube and its mirror
    send_word(make_word(31'h10000, 31'h10000, 0, 31'h12ee6,
                        31'h2000, 31'h199a, 0, 31'hbfe8));
    send_word(make_word(31'h2000, 31'h199a, 0, 31'hbfe8,
                        31'h10000, 31'h10000, 0, 31'h12ee6));
    // strong rarefaction and collision
    send_word(make_word(31'h10000, 31'h666, -32'sh20000, 31'h1000,
                        31'h10000, 31'h666, 32'sh20000, 31'h1000));
    send_word(make_word(31'h10000, 31'h10000, 32'sh7fff0000, 31'h10000,
                        31'h10000, 31'h10000, -32'sh7fff0000, 31'h10000));
    send_word(make_word(1, 1, -1, 0, 1, 1, 1, 0));
    send_word(make_word(31'h55555555, 31'h2aaaaaaa, 32'sh55555555, 31'h2aaaaaaa,
                        31'h2aaaaaaa, 31'h55555555, 32'shaaaaaaaa, 31'h55555555));

    for (int i = 0; i < 950; i++) begin
      if (i == 320) phase = 1;
      if (i == 640) phase = 2;
      if (i == 480) begin
        item_valid <= 1'b0;
        while (sb.pending_star.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      w = ($urandom_range(99) < 70) ? make_plausible() : make_raw();
      send_word(w);
    end
    item_valid <= 1'b0;

    while (sb.pending_star.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_star.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
